### rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define SRMQ_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("sparse table check failed");

// Checked on every clock edge, reset included.
`define SRMQ_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("sparse table reset check failed");

`endif

### rtl/core/srmq_pkg.sv
// Shared types, codes and constants of the sparse table range query unit.
package srmq_pkg;

   localparam int DEPTH_DEFAULT = 1024;
   localparam int VALUE_W       = 32;
   localparam int INDEX_W       = 10;
   localparam int COUNT_W       = 11;
   localparam int ACTION_W      = 2;
   localparam int STATUS_W      = 2;

   // Action codes of a request beat.
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

   // Status codes of a response beat.
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

   // Inverting the sign bit makes unsigned order match signed order.
   localparam logic [VALUE_W-1:0] SIGN_MASK = VALUE_W'(1) << (VALUE_W - 1);

   typedef struct packed {
      logic [ACTION_W-1:0]      action;
      logic signed [VALUE_W-1:0] value;
      logic [INDEX_W-1:0]       from_index;
      logic [INDEX_W-1:0]       to_index;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] result_value;
      logic [STATUS_W-1:0]      status;
      logic [COUNT_W-1:0]       stored_count;
   } rsp_type;

   // A finished result handed from the controller to the response stage.
   typedef struct packed {
      logic    valid;
      rsp_type beat;
   } finish_type;

endpackage

### rtl/core/srmq_ram.sv
// Generic simple dual-read RAM with one write port and registered reads.
module srmq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write and two registered reads per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

### rtl/core/srmq_ctrl.sv
// Sequencer for clear, append and query beats over the sparse table memory.
module srmq_ctrl import srmq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   input  logic                  max_mode,
   input  logic                  slot_free,
   output finish_type            fin,
   output logic                  mem_wr_en,
   output logic [$clog2($clog2(DEPTH + 1)) + $clog2(DEPTH)-1:0] mem_wr_addr,
   output logic [VALUE_W-1:0]    mem_wr_data,
   output logic [$clog2($clog2(DEPTH + 1)) + $clog2(DEPTH)-1:0] mem_rd_addr_a,
   output logic [$clog2($clog2(DEPTH + 1)) + $clog2(DEPTH)-1:0] mem_rd_addr_b,
   input  logic [VALUE_W-1:0]    mem_rd_data_a,
   input  logic [VALUE_W-1:0]    mem_rd_data_b
);

   localparam int AW     = $clog2(DEPTH);
   localparam int LEVELS = $clog2(DEPTH + 1);
   localparam int LW     = $clog2(LEVELS);
   localparam int CW     = $clog2(DEPTH + 1);
   localparam int LEN_W  = INDEX_W + 1;
   localparam int PW     = AW + 2;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_APPEND = 4'b0010,
      S_QUERY  = 4'b0100,
      S_HOLD   = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic [LW-1:0]      lvl_ff, lvl_in;
   logic [VALUE_W-1:0] prev_ff, prev_in;
   rsp_type            pend_ff, pend_in;

   logic               fin_now;
   rsp_type            fin_beat;
   logic               full;
   logic               bad_range;
   logic [LEN_W-1:0]   len;
   logic [LW-1:0]      lg;
   logic [LEN_W-1:0]   second;
   logic [PW-1:0]      idx_plus;
   logic [PW-1:0]      pow_cur;
   logic [PW-1:0]      pow_next;
   logic [PW-1:0]      start_cur;
   logic [PW-1:0]      start_next;
   logic [LW:0]        lvl_next;
   logic [VALUE_W-1:0] picked;
   logic [VALUE_W-1:0] stored_in;

   // Min or max of two sign-flipped values under the current mode.
   function automatic logic [VALUE_W-1:0] pick(input logic [VALUE_W-1:0] a,
                                               input logic [VALUE_W-1:0] b,
                                               input logic mode);
      if (mode) begin
         return (a > b) ? a : b;
      end
      return (a < b) ? a : b;
   endfunction

   // Position of the highest set bit.
   function automatic logic [LW-1:0] top_bit(input logic [LEN_W-1:0] x);
      logic [LW-1:0] b;
      b = '0;
      for (int i = 0; i < LEN_W; i++) begin
         if (x[i]) begin
            b = LW'(i);
         end
      end
      return b;
   endfunction

   // Range check and window placement of a query beat.
   always_comb begin
      full      = (count_ff >= CW'(DEPTH));
      bad_range = (req_data.from_index > req_data.to_index) ||
                  (32'(req_data.to_index) >= 32'(count_ff));
      len       = {1'b0, req_data.to_index} - {1'b0, req_data.from_index} + LEN_W'(1);
      lg        = top_bit(len);
      second    = {1'b0, req_data.to_index} + LEN_W'(1) - (LEN_W'(1) << lg);
      stored_in = VALUE_W'(req_data.value) ^ SIGN_MASK;
   end

   // Window starts of the level being written and of the next level.
   always_comb begin
      idx_plus   = PW'(idx_ff) + PW'(1);
      lvl_next   = {1'b0, lvl_ff} + (LW + 1)'(1);
      pow_cur    = PW'(1) << lvl_ff;
      pow_next   = PW'(1) << lvl_next;
      start_cur  = idx_plus - pow_cur;
      start_next = idx_plus - pow_next;
      picked     = pick(mem_rd_data_a, prev_ff, max_mode);
   end

   // Main sequencer.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      lvl_in        = lvl_ff;
      prev_in       = prev_ff;
      pend_in       = pend_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = '0;
      mem_wr_data   = prev_ff;
      mem_rd_addr_a = '0;
      mem_rd_addr_b = '0;
      fin_now       = 1'b0;
      fin_beat      = '0;
      fin           = '0;
      req_ready     = (state_ff == S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_data.action)
                  ACT_CLEAR: begin
                     count_in = '0;
                     fin_now  = 1'b1;
                  end
                  ACT_APPEND: begin
                     if (full) begin
                        fin_now                = 1'b1;
                        fin_beat.status        = STATUS_FULL;
                        fin_beat.stored_count  = COUNT_W'(count_ff);
                     end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = {LW'(0), AW'(count_ff)};
                        mem_wr_data = stored_in;
                        prev_in     = stored_in;
                        idx_in      = AW'(count_ff);
                        if (count_ff == '0) begin
                           count_in              = count_ff + CW'(1);
                           fin_now               = 1'b1;
                           fin_beat.stored_count = COUNT_W'(count_ff + CW'(1));
                        end else begin
                           // The level one window ends at the new index.
                           mem_rd_addr_a = {LW'(0), AW'(count_ff - CW'(1))};
                           lvl_in        = LW'(1);
                           state_in      = S_APPEND;
                        end
                     end
                  end
                  ACT_QUERY: begin
                     if (bad_range) begin
                        fin_now               = 1'b1;
                        fin_beat.status       = STATUS_BAD_RANGE;
                        fin_beat.stored_count = COUNT_W'(count_ff);
                     end else begin
                        mem_rd_addr_a = {lg, AW'(req_data.from_index)};
                        mem_rd_addr_b = {lg, AW'(second)};
                        state_in      = S_QUERY;
                     end
                  end
                  default: begin
                     fin_now               = 1'b1;
                     fin_beat.stored_count = COUNT_W'(count_ff);
                  end
               endcase
            end
         end
         S_APPEND: begin
            // The upper half was written in the previous cycle and sits in prev_ff.
            mem_wr_en   = 1'b1;
            mem_wr_addr = {lvl_ff, AW'(start_cur)};
            mem_wr_data = picked;
            prev_in     = picked;
            if ((32'(lvl_next) < LEVELS) && (pow_next <= idx_plus)) begin
               mem_rd_addr_a = {lvl_ff, AW'(start_next)};
               lvl_in        = LW'(lvl_next);
            end else begin
               count_in              = count_ff + CW'(1);
               fin_now               = 1'b1;
               fin_beat.stored_count = COUNT_W'(count_ff + CW'(1));
            end
         end
         S_QUERY: begin
            fin_now               = 1'b1;
            fin_beat.result_value = pick(mem_rd_data_a, mem_rd_data_b, max_mode) ^ SIGN_MASK;
            fin_beat.stored_count = COUNT_W'(count_ff);
         end
         S_HOLD: begin
            if (slot_free) begin
               fin.valid = 1'b1;
               fin.beat  = pend_ff;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A finished beat goes straight out or waits for the response slot.
      if (fin_now) begin
         if (slot_free) begin
            fin.valid = 1'b1;
            fin.beat  = fin_beat;
            state_in  = S_IDLE;
         end else begin
            pend_in  = fin_beat;
            state_in = S_HOLD;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Working registers of the current beat.
   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      lvl_ff  <= lvl_in;
      prev_ff <= prev_in;
      pend_ff <= pend_in;
   end

endmodule

### rtl/core/sparse_table_range_min_query_unit.sv
// Top level of the sparse table range minimum and maximum query unit.
//
// Request beats arrive on req_valid/req_ready with a req_type payload: clear,
// append one value at the next index, or query the minimum (maximum when the
// mode bit is set) over an inclusive index range. Every request gives exactly
// one response beat on rsp_valid/rsp_ready with the result, a status code and
// the number of values held afterwards. The user writes the mode bit through
// csr_wr_en/csr_wr_data only while no beat is in flight; the unit does not
// enforce this. A clear, an unused action, an append to an empty or full table
// and a bad range finish in the accept cycle; the response is registered once
// the output register is free. A query waits on the registered read of the
// table memory. An append at index i writes level 0, then each level whose
// window ends at i, one table level per cycle through the single write port.
// The response sits in an output register, so the next request is taken while
// the previous response waits; a finished beat that finds the register full
// waits inside the unit and holds off further requests.
// Reset empties the array and clears the mode bit at once; table contents are
// kept and never read before they are rewritten.
module sparse_table_range_min_query_unit import srmq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_wr_en,
   input  logic    csr_wr_data
);

   localparam int AW       = $clog2(DEPTH);
   localparam int LEVELS   = $clog2(DEPTH + 1);
   localparam int LW       = $clog2(LEVELS);
   localparam int MEM_WORDS = LEVELS << AW;

   logic               max_mode_ff, max_mode_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic               slot_free;
   finish_type         fin;
   logic               mem_wr_en;
   logic [LW+AW-1:0]   mem_wr_addr;
   logic [VALUE_W-1:0] mem_wr_data;
   logic [LW+AW-1:0]   mem_rd_addr_a;
   logic [LW+AW-1:0]   mem_rd_addr_b;
   logic [VALUE_W-1:0] mem_rd_data_a;
   logic [VALUE_W-1:0] mem_rd_data_b;

   srmq_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .max_mode     (max_mode_ff),
      .slot_free    (slot_free),
      .fin          (fin),
      .mem_wr_en    (mem_wr_en),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_data  (mem_wr_data),
      .mem_rd_addr_a(mem_rd_addr_a),
      .mem_rd_addr_b(mem_rd_addr_b),
      .mem_rd_data_a(mem_rd_data_a),
      .mem_rd_data_b(mem_rd_data_b)
   );

   // Levels are stacked in one memory, addressed by level and window start.
   srmq_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(MEM_WORDS)
   ) u_table (
      .clock    (clock),
      .wr_en    (mem_wr_en),
      .wr_addr  (mem_wr_addr),
      .wr_data  (mem_wr_data),
      .rd_addr_a(mem_rd_addr_a),
      .rd_data_a(mem_rd_data_a),
      .rd_addr_b(mem_rd_addr_b),
      .rd_data_b(mem_rd_data_b)
   );

   // Response register and mode bit.
   always_comb begin
      slot_free    = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = fin.valid || (rsp_valid_ff && !rsp_ready);
      rsp_in       = fin.valid ? fin.beat : rsp_ff;
      max_mode_in  = csr_wr_en ? csr_wr_data : max_mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         max_mode_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         max_mode_ff  <= max_mode_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### rtl/core/srmq_checker.sv
// Port-level checks of the sparse table range query unit and their binding.
`include "assert_macros.svh"

module srmq_checker import srmq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // Response beat conditions and the count widened for comparison with the depth.
   logic        flagged;
   logic        full_reject;
   logic [31:0] count_seen;

   assign flagged     = rsp_valid && (rsp_data.status != STATUS_OK);
   assign full_reject = rsp_valid && (rsp_data.status == STATUS_FULL);
   assign count_seen  = 32'(rsp_data.stored_count);

   // A stalled response beat holds.
   `SRMQ_ASSERT(rsp_hold_a, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))

   // No response beat is shown right after reset.
   `SRMQ_ASSERT_ALWAYS(rsp_reset_a, reset |=> !rsp_valid)

   // Flagged beats carry a zero result.
   `SRMQ_ASSERT(flag_zero_a, flagged |-> rsp_data.result_value == 0)

   // A rejected append reports a full table.
   `SRMQ_ASSERT(full_count_a, full_reject |-> count_seen == 32'(DEPTH))

   // The count never exceeds the table depth.
   `SRMQ_ASSERT(count_bound_a, rsp_valid |-> count_seen <= 32'(DEPTH))

endmodule

bind sparse_table_range_min_query_unit srmq_checker #(.DEPTH(DEPTH)) u_srmq_checker (.*);

### sim/sparse_table_range_min_query_unit_tb.sv
// Self-checking testbench for the sparse table range min/max query unit.
module sparse_table_range_min_query_unit_tb;
   import srmq_pkg::*;

   localparam int LEVELS = $clog2(DEPTH_DEFAULT) + 1;
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 4000;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int SETTLE_CYCLES = LEVELS + 2;
   localparam int PHASE_BEATS = 20;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_wr_en = 1'b0;
   logic    csr_wr_data = 1'b0;

   // Request beats waiting to be offered, and responses predicted for accepted beats.
   req_type pending_req[$];
   rsp_type expected_rsp[$];

   // Mirror of the unit: table kept with the sign bit inverted, plus count and mode.
   logic [VALUE_W-1:0] window_table [0:LEVELS-1][0:DEPTH_DEFAULT-1];
   int unsigned held_count = 0;
   logic        max_sel = 1'b0;

   // Occupancy as seen by the stimulus generator, ahead of acceptance.
   int unsigned fill_level = 0;

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned holdoff_left = 0;
   int unsigned quiet_cycles = 0;
   int unsigned mismatch_count = 0;
   int unsigned n_append = 0, n_full = 0, n_query = 0, n_bad = 0;
   int unsigned n_clear = 0, n_unused = 0, n_checked = 0;

   sparse_table_range_min_query_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH: %s", what);
      mismatch_count++;
   endtask

   // Combine two windows under the mode in effect right now.
   function automatic logic [VALUE_W-1:0] merge_window(input logic [VALUE_W-1:0] a,
                                                       input logic [VALUE_W-1:0] b);
      if (max_sel) begin
         return (a > b) ? a : b;
      end
      return (a < b) ? a : b;
   endfunction

   // Apply one accepted beat to the mirror and return the response it must produce.
   function automatic rsp_type apply_beat(input req_type r);
      rsp_type     o;
      int unsigned i, k, s, span, lg, second;
      logic [VALUE_W-1:0] m;
      o = '0;
      case (r.action)
         ACT_CLEAR: begin
            held_count = 0;
            n_clear++;
         end
         ACT_APPEND: begin
            n_append++;
            if (held_count >= DEPTH_DEFAULT) begin
               o.status = STATUS_FULL;
               n_full++;
            end else begin
               i = held_count;
               window_table[0][i] = r.value ^ SIGN_MASK;
               // Every window that ends at the new index, one level at a time.
               for (k = 1; k < LEVELS && (1 << k) <= i + 1; k++) begin
                  s = i + 1 - (1 << k);
                  window_table[k][s] = merge_window(window_table[k-1][s],
                                                    window_table[k-1][s + (1 << (k-1))]);
               end
               held_count = i + 1;
            end
         end
         ACT_QUERY: begin
            n_query++;
            if (r.from_index > r.to_index || r.to_index >= held_count) begin
               o.status = STATUS_BAD_RANGE;
               n_bad++;
            end else begin
               span = r.to_index - r.from_index + 1;
               lg = 0;
               while ((2 << lg) <= span) lg++;
               second = r.to_index + 1 - (1 << lg);
               m = merge_window(window_table[lg][r.from_index], window_table[lg][second]);
               o.result_value = m ^ SIGN_MASK;
            end
         end
         default: begin
            n_unused++;
         end
      endcase
      o.stored_count = COUNT_W'(held_count);
      return o;
   endfunction

   // Driver: record accepted beats, then offer the next one unless idling.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_rsp.push_back(apply_beat(req_data));
         end
         if (!req_valid || req_ready) begin
            if (pending_req.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data  <= pending_req.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each response beat with the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch($sformatf("response beat with nothing expected: %p", rsp_data));
            end else begin
               want = expected_rsp.pop_front();
               n_checked++;
               if (rsp_data.result_value !== want.result_value) begin
                  report_mismatch($sformatf("result_value %0d, expected %0d",
                                            rsp_data.result_value, want.result_value));
               end
               if (rsp_data.status !== want.status) begin
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_data.status, want.status));
               end
               if (rsp_data.stored_count !== want.stored_count) begin
                  report_mismatch($sformatf("stored_count %0d, expected %0d",
                                            rsp_data.stored_count, want.stored_count));
               end
            end
         end
         rsp_ready <= (holdoff_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Long receiver hold-off, counted down here once the stimulus arms it.
   always @(posedge clock) begin
      if (holdoff_left != 0) begin
         holdoff_left <= holdoff_left - 1;
      end
   end

   // Watchdog: work outstanding but no beat moving on either channel.
   always @(posedge clock) begin
      if (!reset && (pending_req.size() > 0 || req_valid || expected_rsp.size() > 0)
          && !(req_valid && req_ready) && !(rsp_valid && rsp_ready)) begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
            $display("sparse_table_range_min_query_unit_tb NOT OK");
            $finish;
         end
      end else begin
         quiet_cycles = 0;
      end
   end

   task automatic push_beat(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] v,
                            input int unsigned from_i, input int unsigned to_i);
      req_type r;
      r.action     = act;
      r.value      = v;
      r.from_index = INDEX_W'(from_i);
      r.to_index   = INDEX_W'(to_i);
      if (act == ACT_CLEAR) begin
         fill_level = 0;
      end else if (act == ACT_APPEND && fill_level < DEPTH_DEFAULT) begin
         fill_level++;
      end
      pending_req.push_back(r);
   endtask

   // Wait until every beat has been answered, then wait out a settling period.
   task automatic wait_idle();
      do @(posedge clock);
      while (pending_req.size() > 0 || req_valid || expected_rsp.size() > 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_mode(input logic m);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      max_sel     <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Values lean toward the extremes and a narrow band so ties are common.
   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(7))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'($signed($urandom_range(20)) - 10);
         default: return $urandom;
      endcase
   endfunction

   // Mostly valid queries and appends, with clears, unused codes and bad ranges mixed in.
   task automatic push_random_beat();
      int unsigned pick, to_i, from_i;
      pick = $urandom_range(99);
      if (pick < 2) begin
         push_beat(ACT_CLEAR, $urandom, $urandom, $urandom);
      end else if (pick < 4) begin
         push_beat(ACT_UNUSED, $urandom, $urandom, $urandom);
      end else if (pick < 50) begin
         push_beat(ACT_APPEND, pick_value(), $urandom, $urandom);
      end else if (pick < 88 && fill_level > 0) begin
         to_i = $urandom_range(fill_level - 1);
         case ($urandom_range(3))
            0: from_i = to_i;
            1: from_i = (to_i > 3) ? to_i - $urandom_range(3) : 0;
            default: from_i = $urandom_range(to_i);
         endcase
         push_beat(ACT_QUERY, $urandom, from_i, to_i);
      end else if (pick < 94 && fill_level > 1) begin
         // Reversed range within the held values.
         from_i = $urandom_range(fill_level - 1, 1);
         push_beat(ACT_QUERY, $urandom, from_i, $urandom_range(from_i - 1));
      end else begin
         push_beat(ACT_QUERY, $urandom, $urandom, $urandom);
      end
   endtask

   initial begin
      int unsigned n, phase;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, unused code, extreme values, edge ranges.
      push_beat(ACT_QUERY, 0, 0, 0);
      push_beat(ACT_UNUSED, 32'hffff_ffff, 10'h3ff, 10'h3ff);
      push_beat(ACT_CLEAR, 0, 0, 0);
      push_beat(ACT_APPEND, 32'h7fff_ffff, 0, 0);
      push_beat(ACT_APPEND, 32'h8000_0000, 0, 0);
      push_beat(ACT_APPEND, 32'h0000_0000, 0, 0);
      push_beat(ACT_APPEND, 32'hffff_ffff, 0, 0);
      push_beat(ACT_APPEND, 32'h0000_0001, 0, 0);
      push_beat(ACT_QUERY, 0, 0, 0);
      push_beat(ACT_QUERY, 0, 0, 4);
      push_beat(ACT_QUERY, 0, 2, 4);
      push_beat(ACT_QUERY, 0, 3, 1);
      push_beat(ACT_QUERY, 0, 0, 5);
      push_beat(ACT_QUERY, 0, 0, 10'h3ff);
      set_mode(1'b1);
      // Entries written under minimum, combined now under maximum.
      push_beat(ACT_QUERY, 0, 0, 4);
      push_beat(ACT_QUERY, 0, 1, 2);
      push_beat(ACT_APPEND, 32'h8000_0000, 0, 0);
      push_beat(ACT_QUERY, 0, 4, 5);
      push_beat(ACT_QUERY, 0, 5, 5);
      push_beat(ACT_CLEAR, 0, 0, 0);
      push_beat(ACT_QUERY, 0, 0, 0);
      push_beat(ACT_APPEND, 32'h1234_5678, 0, 0);
      push_beat(ACT_QUERY, 0, 0, 0);
      wait_idle();

      // Fill to capacity, then appends to a full table and full-width queries.
      set_mode(1'($urandom_range(1)));
      send_idle_pct  <= 10;
      recv_stall_pct <= 10;
      push_beat(ACT_CLEAR, 0, 0, 0);
      for (n = 0; n < DEPTH_DEFAULT; n++) begin
         push_beat(ACT_APPEND, pick_value(), 0, 0);
      end
      push_beat(ACT_APPEND, 32'h7fff_ffff, 0, 0);
      push_beat(ACT_APPEND, 32'h8000_0000, 0, 0);
      push_beat(ACT_QUERY, 0, 0, 10'h3ff);
      push_beat(ACT_QUERY, 0, 10'h3ff, 10'h3ff);
      push_beat(ACT_QUERY, 0, 1, 10'h3ff);
      push_beat(ACT_QUERY, 0, 0, 10'h3fe);
      push_beat(ACT_QUERY, 0, 10'h200, 10'h1ff);
      wait_idle();
      set_mode(~max_sel);
      for (n = 0; n < 20; n++) begin
         push_random_beat();
      end
      push_beat(ACT_QUERY, 0, 0, 10'h3ff);
      push_beat(ACT_CLEAR, 0, 0, 0);
      wait_idle();

      // Random part: four idling mixes, mode flipped between them with values kept.
      for (phase = 0; phase < 4; phase++) begin
         set_mode(phase[0]);
         case (phase)
            0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
            1: begin send_idle_pct <= 83; recv_stall_pct <= 0;  end
            2: begin send_idle_pct <= 0;  recv_stall_pct <= 83; end
            default: begin send_idle_pct <= 30; recv_stall_pct <= 30; end
         endcase
         for (n = 0; n < PHASE_BEATS; n++) begin
            push_random_beat();
         end
         if (phase == 0) begin
            // Receiver holds off while the sender keeps offering beats.
            @(posedge clock);
            holdoff_left <= HOLDOFF_CYCLES;
         end
         wait_idle();
      end

      $display("Covered %0d appends (%0d to a full table), %0d queries (%0d bad ranges),",
               n_append, n_full, n_query, n_bad);
      $display("%0d clears and %0d unused codes; %0d responses checked in both modes.",
               n_clear, n_unused, n_checked);
      if (mismatch_count == 0) begin
         $display("sparse_table_range_min_query_unit_tb OK");
      end else begin
         $display("sparse_table_range_min_query_unit_tb NOT OK");
      end
      $finish;
   end

endmodule

### files.f
+incdir+rtl/core
rtl/core/srmq_pkg.sv
rtl/core/srmq_ram.sv
rtl/core/srmq_ctrl.sv
rtl/core/sparse_table_range_min_query_unit.sv
rtl/core/srmq_checker.sv
sim/sparse_table_range_min_query_unit_tb.sv
